FILE: rtl/nca_pkg.sv
// nca_pkg: shared types, constants and helpers for the nearest centroid assignment block
// depends on nothing; used by every module under rtl except nca_ram
package nca_pkg;

  localparam int unsigned NUM_LANES   = 16;
  localparam int unsigned NUM_COORDS  = 8;
  localparam int unsigned COORD_W     = 16;
  localparam int unsigned CLUSTER_W   = 4;
  localparam int unsigned COORD_IDX_W = 3;
  localparam int unsigned LABEL_W     = 5;
  localparam int unsigned DIST_W      = 35;
  localparam int unsigned ABS_W       = 16;
  localparam int unsigned TERM_W      = 32;
  localparam int unsigned POS_W       = $clog2(NUM_COORDS + 1);
  localparam int unsigned TREE_LEVELS = $clog2(NUM_LANES);

  localparam int unsigned CCOUNT_W = 5;
  localparam int unsigned NCOORD_W = 4;
  localparam int unsigned TOL_W    = 16;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_METRIC_MODE     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CLUSTER_COUNT   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_COORD_COUNT     = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_MATCH_TOLERANCE = 2'd3;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_POINT = 1'b1;

  localparam logic METRIC_EUCLID   = 1'b0;
  localparam logic METRIC_MISMATCH = 1'b1;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  typedef struct packed {
    logic                      operation;
    logic [CLUSTER_W-1:0]      cluster_index;
    logic [COORD_IDX_W-1:0]    coord_index;
    logic signed [COORD_W-1:0] coord_value;
    logic                      last_coord;
    logic [LABEL_W-1:0]        previous_label;
  } in_item_t;

  typedef struct packed {
    logic [CLUSTER_W-1:0] nearest_cluster;
    logic [DIST_W-1:0]    best_distance;
    logic                 label_changed;
  } out_item_t;

  // control bundle from the top level to every cluster lane
  typedef struct packed {
    logic [COORD_IDX_W-1:0] ram_waddr;
    logic [COORD_W-1:0]     ram_wdata;
    logic                   ram_re;
    logic [COORD_IDX_W-1:0] ram_raddr;
    logic [COORD_W-1:0]     point_value;
    logic                   p2_en;
    logic                   p3_en;
    logic                   acc_add;
    logic                   acc_end;
    logic                   metric_mode;
    logic [TOL_W-1:0]       match_tolerance;
  } lane_ctrl_t;

  typedef struct packed {
    logic                 valid;
    logic [CLUSTER_W-1:0] index;
    logic [DIST_W-1:0]    distance;
  } node_t;

  // left operand carries the lower cluster index, so it wins ties
  function automatic node_t better_node(node_t a, node_t b);
    node_t r;
    if (a.valid && (!b.valid || (a.distance <= b.distance))) begin
      r = a;
    end else begin
      r = b;
    end
    return r;
  endfunction

endpackage

FILE: rtl/nearest_centroid_assign_unit.sv
// nearest_centroid_assign_unit: top level, transfer handshake, registers, lane array
// depends on nca_pkg, nca_lane, nca_min_tree
// ---------------------------------------------------------------------------
// Takes one item per clock cycle while not stalled, loads and point coordinates
// alike, and never pauses for a result: each point coordinate is compared
// against all sixteen centroids in parallel lanes (one subtract, one square or
// tolerance compare and one saturating add per lane), and the closing coordinate
// of a point feeds a four-level registered min tree that runs alongside the
// following points. A result goes through the difference, term and distance
// registers and the tree levels to the output register; the input stalls only
// when the output register holds a stalled result and all stages behind it are
// full. Centroids must be loaded before they are used; their store has no reset.
// ---------------------------------------------------------------------------
module nearest_centroid_assign_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  nca_pkg::in_item_t               in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output nca_pkg::out_item_t              out_item_o,
  input  logic                            cfg_we_i,
  input  logic [nca_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [nca_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);

  localparam int unsigned Lanes = nca_pkg::NUM_LANES;

  // configuration registers
  logic                          metric_mode_q;
  logic [nca_pkg::CCOUNT_W-1:0]  cluster_count_q;
  logic [nca_pkg::NCOORD_W-1:0]  coord_count_q;
  logic [nca_pkg::TOL_W-1:0]     match_tolerance_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      metric_mode_q     <= nca_pkg::METRIC_EUCLID;
      cluster_count_q   <= nca_pkg::CCOUNT_W'(1);
      coord_count_q     <= nca_pkg::NCOORD_W'(2);
      match_tolerance_q <= nca_pkg::TOL_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        nca_pkg::CFG_METRIC_MODE: begin
          metric_mode_q <= cfg_wdata_i[0];
        end
        nca_pkg::CFG_CLUSTER_COUNT: begin
          cluster_count_q <= cfg_wdata_i[nca_pkg::CCOUNT_W-1:0];
        end
        nca_pkg::CFG_COORD_COUNT: begin
          coord_count_q <= cfg_wdata_i[nca_pkg::NCOORD_W-1:0];
        end
        nca_pkg::CFG_MATCH_TOLERANCE: begin
          match_tolerance_q <= cfg_wdata_i[nca_pkg::TOL_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  logic [nca_pkg::CCOUNT_W-1:0] nclu;
  logic [nca_pkg::NCOORD_W-1:0] ncoo;
  logic [Lanes-1:0]             active;

  always_comb begin
    if (cluster_count_q == '0) begin
      nclu = nca_pkg::CCOUNT_W'(1);
    end else if (32'(cluster_count_q) > Lanes) begin
      nclu = nca_pkg::CCOUNT_W'(Lanes);
    end else begin
      nclu = cluster_count_q;
    end
    if (32'(coord_count_q) > nca_pkg::NUM_COORDS) begin
      ncoo = nca_pkg::NCOORD_W'(nca_pkg::NUM_COORDS);
    end else begin
      ncoo = coord_count_q;
    end
    for (int k = 0; k < Lanes; k++) begin
      active[k] = 32'(k) < 32'(nclu);
    end
  end

  // pipeline stage valids and item sidebands
  logic                         v1_q, v2_q, v3_q, v4_q;
  logic                         last1_q, last2_q, last3_q;
  logic                         cnt1_q, cnt2_q, cnt3_q;
  logic [nca_pkg::LABEL_W-1:0]  prev1_q, prev2_q, prev3_q, prev4_q;
  logic [nca_pkg::COORD_W-1:0]  value1_q;
  logic [nca_pkg::POS_W-1:0]    pos_q;

  logic ready1, ready2, ready3, ready4, leave3;
  logic tree_in_ready;
  logic tree_valid;
  logic out_ready;
  logic in_accept;
  logic point_accept;
  logic load_accept;
  logic load_in_range;

  assign leave3 = v3_q && (!last3_q || ready4);
  assign ready4 = !v4_q || tree_in_ready;
  assign ready3 = !v3_q || leave3;
  assign ready2 = !v2_q || ready3;
  assign ready1 = !v1_q || ready2;

  assign in_stall_o    = !ready1;
  assign in_accept     = in_valid_i && ready1;
  assign point_accept  = in_accept && (in_item_i.operation == nca_pkg::OP_POINT);
  assign load_accept   = in_accept && (in_item_i.operation == nca_pkg::OP_LOAD);
  assign load_in_range = (32'(in_item_i.cluster_index) < Lanes)
                      && (32'(in_item_i.coord_index) < nca_pkg::NUM_COORDS);

  // coordinate position, saturating at the store depth
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (point_accept) begin
      if (in_item_i.last_coord) begin
        pos_q <= '0;
      end else if (32'(pos_q) < nca_pkg::NUM_COORDS) begin
        pos_q <= pos_q + nca_pkg::POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (ready1) begin
        v1_q <= point_accept;
      end
      if (ready2) begin
        v2_q <= v1_q;
      end
      if (ready3) begin
        v3_q <= v2_q;
      end
      if (ready4) begin
        v4_q <= v3_q && last3_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready1) begin
      last1_q  <= in_item_i.last_coord;
      cnt1_q   <= pos_q < ncoo;
      prev1_q  <= in_item_i.previous_label;
      value1_q <= in_item_i.coord_value;
    end
    if (ready2) begin
      last2_q <= last1_q;
      cnt2_q  <= cnt1_q;
      prev2_q <= prev1_q;
    end
    if (ready3) begin
      last3_q <= last2_q;
      cnt3_q  <= cnt2_q;
      prev3_q <= prev2_q;
    end
    if (ready4) begin
      prev4_q <= prev3_q;
    end
  end

  nca_pkg::lane_ctrl_t ctrl;

  always_comb begin
    ctrl.ram_waddr       = in_item_i.coord_index;
    ctrl.ram_wdata       = in_item_i.coord_value;
    ctrl.ram_re          = point_accept;
    ctrl.ram_raddr       = pos_q[nca_pkg::COORD_IDX_W-1:0];
    ctrl.point_value     = value1_q;
    ctrl.p2_en           = ready2;
    ctrl.p3_en           = ready3;
    ctrl.acc_add         = leave3 && cnt3_q;
    ctrl.acc_end         = leave3 && last3_q;
    ctrl.metric_mode     = metric_mode_q;
    ctrl.match_tolerance = match_tolerance_q;
  end

  nca_pkg::node_t leaves [Lanes];

  for (genvar k = 0; k < Lanes; k++) begin : g_lane
    logic                       wr_sel;
    logic [nca_pkg::DIST_W-1:0] lane_dist;

    assign wr_sel = load_accept && load_in_range
                 && (32'(in_item_i.cluster_index) == k);

    nca_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .wr_sel_i(wr_sel),
      .active_i(active[k]),
      .dist_o  (lane_dist)
    );

    assign leaves[k].valid    = active[k];
    assign leaves[k].index    = nca_pkg::CLUSTER_W'(k);
    assign leaves[k].distance = lane_dist;
  end

  nca_pkg::node_t              best;
  logic [nca_pkg::LABEL_W-1:0] best_label;

  nca_min_tree u_tree (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (v4_q),
    .in_ready_o (tree_in_ready),
    .in_nodes_i (leaves),
    .in_label_i (prev4_q),
    .out_valid_o(tree_valid),
    .out_ready_i(out_ready),
    .out_node_o (best),
    .out_label_o(best_label)
  );

  // output register
  logic                out_valid_q;
  nca_pkg::out_item_t  out_q;

  assign out_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= tree_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready) begin
      out_q.nearest_cluster <= best.index;
      out_q.best_distance   <= best.distance;
      out_q.label_changed   <= {1'b0, best.index} != best_label;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // load transfers leave the coordinate position alone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_accept |=> $stable(pos_q))
    else $error("coordinate position moved on a load transfer");

  // closing coordinate of a point rewinds the position
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (point_accept && in_item_i.last_coord) |=> (pos_q == '0))
    else $error("position not cleared after last coordinate");

  // position never passes the store depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(pos_q) <= nca_pkg::NUM_COORDS)
    else $error("coordinate position out of range");

  // only a closing coordinate may enter the min search
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ready4 && v3_q && !last3_q) |=> !v4_q)
    else $error("non-final coordinate reached the min search");

endmodule

FILE: rtl/nca_ram.sv
// nca_ram: generic single write port, single read port ram with registered read data
// no dependencies
module nca_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/nca_lane.sv
// nca_lane: one cluster lane: centroid coordinates, difference, distance term, accumulator
// depends on nca_pkg and nca_ram
module nca_lane (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  nca_pkg::lane_ctrl_t        ctrl_i,
  input  logic                       wr_sel_i,
  input  logic                       active_i,
  output logic [nca_pkg::DIST_W-1:0] dist_o
);

  logic [nca_pkg::COORD_W-1:0] centroid;
  logic [nca_pkg::COORD_W:0]   diff;
  logic [nca_pkg::ABS_W-1:0]   abs_d;
  logic [nca_pkg::ABS_W-1:0]   abs_q;
  logic [2*nca_pkg::ABS_W-1:0] square;
  logic [nca_pkg::TERM_W-1:0]  term_d;
  logic [nca_pkg::TERM_W-1:0]  term_q;
  logic [nca_pkg::DIST_W:0]    sum;
  logic [nca_pkg::DIST_W-1:0]  sat_sum;
  logic [nca_pkg::DIST_W-1:0]  acc_new;
  logic [nca_pkg::DIST_W-1:0]  acc_q;
  logic [nca_pkg::DIST_W-1:0]  dist_q;

  nca_ram #(
    .WIDTH(nca_pkg::COORD_W),
    .DEPTH(nca_pkg::NUM_COORDS)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (wr_sel_i),
    .waddr_i(ctrl_i.ram_waddr),
    .wdata_i(ctrl_i.ram_wdata),
    .re_i   (ctrl_i.ram_re),
    .raddr_i(ctrl_i.ram_raddr),
    .rdata_o(centroid)
  );

  // 17-bit signed difference, magnitude always fits 16 bits
  assign diff  = {ctrl_i.point_value[nca_pkg::COORD_W-1], ctrl_i.point_value}
               - {centroid[nca_pkg::COORD_W-1], centroid};
  assign abs_d = diff[nca_pkg::COORD_W] ? nca_pkg::ABS_W'(-diff) : diff[nca_pkg::ABS_W-1:0];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.p2_en) begin
      abs_q <= abs_d;
    end
  end

  assign square = abs_q * abs_q;

  always_comb begin
    if (ctrl_i.metric_mode == nca_pkg::METRIC_MISMATCH) begin
      term_d = (abs_q >= ctrl_i.match_tolerance) ? nca_pkg::TERM_W'(1) : '0;
    end else begin
      term_d = square[nca_pkg::TERM_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.p3_en) begin
      term_q <= term_d;
    end
  end

  assign sum     = {1'b0, acc_q} + (nca_pkg::DIST_W + 1)'(term_q);
  assign sat_sum = sum[nca_pkg::DIST_W] ? nca_pkg::DIST_MAX : sum[nca_pkg::DIST_W-1:0];
  assign acc_new = (ctrl_i.acc_add && active_i) ? sat_sum : acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (ctrl_i.acc_end) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_new;
    end
  end

  // snapshot of the finished point distance for the min search
  always_ff @(posedge clk_i) begin
    if (ctrl_i.acc_end) begin
      dist_q <= acc_new;
    end
  end

  assign dist_o = dist_q;

endmodule

FILE: rtl/nca_min_tree.sv
// nca_min_tree: registered binary min tree over the lane distances, one level per stage
// depends on nca_pkg
module nca_min_tree (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  nca_pkg::node_t              in_nodes_i [nca_pkg::NUM_LANES],
  input  logic [nca_pkg::LABEL_W-1:0] in_label_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output nca_pkg::node_t              out_node_o,
  output logic [nca_pkg::LABEL_W-1:0] out_label_o
);

  localparam int unsigned Levels = nca_pkg::TREE_LEVELS;
  localparam int unsigned Inner  = nca_pkg::NUM_LANES - 1;

  // heap order: node i has children 2i+1 and 2i+2, leaves are the lane inputs
  nca_pkg::node_t             node_q [Inner];
  logic [Levels-1:0]          v_q;
  logic [nca_pkg::LABEL_W-1:0] label_q [Levels];
  logic [Levels-1:0]          stage_ready;
  logic [Levels:0]            next_ready;
  logic [Levels:0]            src_valid;
  logic [nca_pkg::LABEL_W-1:0] src_label [Levels+1];

  assign next_ready[0]     = out_ready_i;
  assign src_valid[Levels] = in_valid_i;
  assign src_label[Levels] = in_label_i;

  for (genvar d = 0; d < Levels; d++) begin : g_stage
    assign stage_ready[d]  = !v_q[d] || next_ready[d];
    assign next_ready[d+1] = stage_ready[d];
    assign src_valid[d]    = v_q[d];
    assign src_label[d]    = label_q[d];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[d] <= 1'b0;
      end else if (stage_ready[d]) begin
        v_q[d] <= src_valid[d+1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (stage_ready[d]) begin
        label_q[d] <= src_label[d+1];
      end
    end
  end

  for (genvar i = 0; i < Inner; i++) begin : g_node
    localparam int unsigned Depth = $clog2(i + 2) - 1;
    nca_pkg::node_t left;
    nca_pkg::node_t right;

    if (2 * i + 1 >= Inner) begin : g_leaf
      assign left  = in_nodes_i[2*i+1-Inner];
      assign right = in_nodes_i[2*i+2-Inner];
    end else begin : g_inner
      assign left  = node_q[2*i+1];
      assign right = node_q[2*i+2];
    end

    always_ff @(posedge clk_i) begin
      if (stage_ready[Depth]) begin
        node_q[i] <= nca_pkg::better_node(left, right);
      end
    end
  end

  assign in_ready_o  = stage_ready[Levels-1];
  assign out_valid_o = v_q[0];
  assign out_node_o  = node_q[0];
  assign out_label_o = label_q[0];

endmodule

FILE: dv/nca_assign_checker.sv
// nca_assign_checker: watches the item, result and register ports of the nearest centroid
// assignment unit, predicts each assignment and compares it with the one observed
// depends on nca_pkg
module nca_assign_checker
  import nca_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_stall_i,
  input  in_item_t               in_item_i,
  input  logic                   out_valid_i,
  input  logic                   out_stall_i,
  input  out_item_t              out_item_i,
  input  logic                   cfg_we_i,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i,
  output int                     fail_count_o,
  output int                     pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PRINT_CAP = 40;

  logic signed [COORD_W-1:0] centroid_mem [NUM_LANES][NUM_COORDS];
  logic [DIST_W-1:0]         dist_acc [NUM_LANES];
  int unsigned               coord_pos;

  logic                      metric_sel;
  logic [CCOUNT_W-1:0]       cluster_cfg;
  logic [NCOORD_W-1:0]       coord_cfg;
  logic [TOL_W-1:0]          tol_cfg;

  out_item_t                 expected_assign_q [$];

  task automatic report_mismatch(input string msg);
    fail_count_o++;
    if (fail_count_o <= PRINT_CAP) $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  task automatic write_setting(input logic [CFG_INDEX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_METRIC_MODE:     metric_sel  = data[0];
      CFG_CLUSTER_COUNT:   cluster_cfg = data[CCOUNT_W-1:0];
      CFG_COORD_COUNT:     coord_cfg   = data[NCOORD_W-1:0];
      CFG_MATCH_TOLERANCE: tol_cfg     = data[TOL_W-1:0];
      default: ;
    endcase
  endtask

  // one accepted item: a centroid load, or one coordinate of a point
  task automatic take_item(input in_item_t item);
    int unsigned       lanes;
    int unsigned       coords;
    int unsigned       best;
    longint            diff;
    longint unsigned   mag;
    longint unsigned   term;
    longint unsigned   sum;
    logic [DIST_W-1:0] best_dist;
    out_item_t         res;
    if (item.operation == OP_LOAD) begin
      centroid_mem[item.cluster_index][item.coord_index] = item.coord_value;
    end else begin
      lanes  = (cluster_cfg == 0) ? 1 :
               ((cluster_cfg > NUM_LANES) ? NUM_LANES : cluster_cfg);
      coords = (coord_cfg > NUM_COORDS) ? NUM_COORDS : coord_cfg;
      if (coord_pos < coords) begin
        for (int k = 0; k < lanes; k++) begin
          diff = longint'($signed(item.coord_value)) - longint'(centroid_mem[k][coord_pos]);
          mag  = $unsigned((diff < 0) ? -diff : diff);
          if (metric_sel == METRIC_EUCLID) begin
            term = mag * mag;
          end else begin
            term = (mag >= tol_cfg) ? 64'd1 : 64'd0;
          end
          if (term > DIST_MAX) term = DIST_MAX;
          sum = dist_acc[k] + term;
          dist_acc[k] = (sum > DIST_MAX) ? DIST_MAX : sum[DIST_W-1:0];
        end
      end
      // position sticks at the end once extra coordinates arrive
      if (coord_pos < NUM_COORDS) coord_pos++;
      if (item.last_coord) begin
        best      = 0;
        best_dist = dist_acc[0];
        for (int k = 1; k < lanes; k++) begin
          if (dist_acc[k] < best_dist) begin
            best_dist = dist_acc[k];
            best      = k;
          end
        end
        res.nearest_cluster = best[CLUSTER_W-1:0];
        res.best_distance   = best_dist;
        res.label_changed   = (best != item.previous_label);
        expected_assign_q.push_back(res);
        foreach (dist_acc[k]) dist_acc[k] = '0;
        coord_pos = 0;
      end
    end
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (expected_assign_q.size() == 0) begin
      report_mismatch($sformatf("result with nothing expected: cluster %0d distance %0d",
                                got.nearest_cluster, got.best_distance));
    end else begin
      want = expected_assign_q.pop_front();
      if (got.nearest_cluster !== want.nearest_cluster)
        report_mismatch($sformatf("nearest_cluster %0d, expected %0d",
                                  got.nearest_cluster, want.nearest_cluster));
      if (got.best_distance !== want.best_distance)
        report_mismatch($sformatf("best_distance %0d, expected %0d",
                                  got.best_distance, want.best_distance));
      if (got.label_changed !== want.label_changed)
        report_mismatch($sformatf("label_changed %0b, expected %0b",
                                  got.label_changed, want.label_changed));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (dist_acc[k]) dist_acc[k] = '0;
      coord_pos   = 0;
      metric_sel  = METRIC_EUCLID;
      cluster_cfg = CCOUNT_W'(1);
      coord_cfg   = NCOORD_W'(2);
      tol_cfg     = TOL_W'(1);
      expected_assign_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) check_result(out_item_i);
      if (cfg_we_i) write_setting(cfg_index_i, cfg_wdata_i);
      if (in_valid_i && !in_stall_i) take_item(in_item_i);
    end
    pending_o = expected_assign_q.size();
  end

endmodule

FILE: dv/nearest_centroid_assign_unit_tb.sv
// nearest_centroid_assign_unit_tb: clock, reset, register settings and item stimulus
// for the nearest centroid assignment unit; checking is done by nca_assign_checker
// depends on nca_pkg, nca_assign_checker and the rtl top level
module nearest_centroid_assign_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import nca_pkg::*;

  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned RANDOM_ITEMS = 1800;

  logic                   clk;
  logic                   rst_n     = 1'b0;
  logic                   in_valid  = 1'b0;
  in_item_t               in_item   = '0;
  logic                   out_stall = 1'b0;
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
  logic                   in_stall;
  logic                   out_valid;
  out_item_t              out_item;
  int                     fail_count;
  int                     pending;

  bit                     idle_en = 1'b1;
  int                     sent_items = 0;

  nearest_centroid_assign_unit u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata)
  );

  nca_assign_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_item_i   (out_item),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  // result side back-pressure in bursts
  always begin
    @(posedge clk);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      repeat ($urandom_range(1, 9)) @(posedge clk);
      out_stall <= 1'b0;
    end
  end

  function automatic logic signed [COORD_W-1:0] pick_coord();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return '0;
      3, 4, 5: return COORD_W'(int'($urandom_range(0, 1023)) - 512);
      default: return COORD_W'($urandom);
    endcase
  endfunction

  function automatic logic [LABEL_W-1:0] pick_label();
    if ($urandom_range(0, 3) == 0) return LABEL_W'($urandom_range(16, 31));
    return LABEL_W'($urandom_range(0, 15));
  endfunction

  task automatic send_item(input in_item_t item);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_items++;
  endtask

  task automatic load_centroid(input int unsigned k, input int unsigned p,
                               input logic signed [COORD_W-1:0] value);
    in_item_t item;
    item.operation      = OP_LOAD;
    item.cluster_index  = CLUSTER_W'(k);
    item.coord_index    = COORD_IDX_W'(p);
    item.coord_value    = value;
    item.last_coord     = 1'($urandom);
    item.previous_label = LABEL_W'($urandom);
    send_item(item);
  endtask

  task automatic send_coord(input logic signed [COORD_W-1:0] value, input logic last,
                            input logic [LABEL_W-1:0] label);
    in_item_t item;
    item.operation      = OP_POINT;
    item.cluster_index  = CLUSTER_W'($urandom);
    item.coord_index    = COORD_IDX_W'($urandom);
    item.coord_value    = value;
    item.last_coord     = last;
    item.previous_label = label;
    send_item(item);
  endtask

  task automatic send_point(input int unsigned len, input logic [LABEL_W-1:0] label);
    for (int i = 0; i < len; i++) send_coord(pick_coord(), i == len - 1, label);
  endtask

  // registers change only once the pipeline has emptied
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int unsigned data);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DATA_W'(data);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic apply_settings(input logic metric, input int unsigned clusters,
                                input int unsigned coords, input int unsigned tol);
    write_reg(CFG_METRIC_MODE, metric);
    write_reg(CFG_CLUSTER_COUNT, clusters);
    write_reg(CFG_COORD_COUNT, coords);
    write_reg(CFG_MATCH_TOLERANCE, tol);
  endtask

  initial begin
    int unsigned clusters;
    int unsigned coords;
    int unsigned tol;
    int unsigned plen;
    int unsigned sel;
    int          random_start;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // the store has no reset, so every entry is written before any point
    apply_settings(METRIC_EUCLID, 16, 8, 1);
    for (int k = 0; k < NUM_LANES; k++)
      for (int p = 0; p < NUM_COORDS; p++) load_centroid(k, p, pick_coord());

    // widest possible coordinate differences on a single cluster
    apply_settings(METRIC_EUCLID, 1, 2, 1);
    load_centroid(0, 0, 16'sh8000);
    load_centroid(0, 1, 16'sh7fff);
    send_coord(16'sh7fff, 1'b0, LABEL_W'(16));
    send_coord(16'sh8000, 1'b1, LABEL_W'(16));
    // coordinates past coord_count add nothing
    apply_settings(METRIC_EUCLID, 16, 1, 1);
    send_point(3, pick_label());
    // point closed early
    apply_settings(METRIC_EUCLID, 16, 8, 1);
    send_point(1, pick_label());
    // no coordinate counts, all tie at zero
    apply_settings(METRIC_EUCLID, 16, 0, 1);
    send_point(2, LABEL_W'(0));
    // both counts beyond range, position saturates
    apply_settings(METRIC_EUCLID, 31, 15, 1);
    send_point(9, LABEL_W'(31));
    // zero tolerance with cluster count zero
    apply_settings(METRIC_MISMATCH, 0, 2, 0);
    send_point(2, pick_label());
    apply_settings(METRIC_MISMATCH, 16, 8, 65535);
    send_coord(16'sh7fff, 1'b1, pick_label());
    // settings change part way through a point
    apply_settings(METRIC_EUCLID, 4, 3, 1);
    send_coord(pick_coord(), 1'b0, pick_label());
    apply_settings(METRIC_MISMATCH, 4, 3, 200);
    send_coord(pick_coord(), 1'b0, LABEL_W'(2));
    send_coord(pick_coord(), 1'b1, LABEL_W'(2));

    random_start = sent_items;
    while (sent_items - random_start < RANDOM_ITEMS) begin
      idle_en = (sent_items - random_start < RANDOM_ITEMS * 5 / 6) &&
                ($urandom_range(0, 3) != 0);
      sel = $urandom_range(0, 9);
      clusters = (sel < 6) ? $urandom_range(1, 16) : (sel == 6) ? 16 : (sel == 7) ? 1 :
                 (sel == 8) ? 0 : $urandom_range(17, 31);
      sel = $urandom_range(0, 9);
      coords = (sel < 7) ? $urandom_range(1, 8) : (sel == 7) ? 8 : (sel == 8) ? 0 :
               $urandom_range(9, 15);
      sel = $urandom_range(0, 9);
      tol = (sel == 0) ? 0 : (sel == 1) ? 65535 : (sel < 6) ? $urandom_range(1, 600) :
            $urandom_range(0, 65535);
      apply_settings(1'($urandom), clusters, coords, tol);
      plen = (coords == 0) ? 1 : (coords > NUM_COORDS) ? NUM_COORDS : coords;
      repeat ($urandom_range(8, 30)) begin
        sel = $urandom_range(0, 19);
        if (sel < 14) begin
          send_point((coords > NUM_COORDS) ? plen + $urandom_range(0, 2) : plen,
                     pick_label());
        end else if (sel < 17) begin
          repeat ($urandom_range(1, 4))
            load_centroid($urandom_range(0, 15), $urandom_range(0, 7), pick_coord());
        end else if (sel < 19) begin
          // unterminated coordinates, may run on into the next point
          repeat ($urandom_range(1, 3)) send_coord(pick_coord(), 1'b0, pick_label());
        end else begin
          send_point($urandom_range(1, 10), pick_label());
        end
      end
    end

    idle_en = 1'b0;
    in_valid <= 1'b0;
    @(posedge clk);
    for (int n = 0; n < 20000 && pending != 0; n++) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
